// ----- rtl/stdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sieve factorizer package
// Shared widths, register codes and the divider request/response words.
// ----------------------------------------------------------------------------
`default_nettype none

package stdf_pkg;

  localparam int FACTOR_W  = 31;
  localparam int LIMIT_W   = 16;
  localparam int DIV_STEPS = FACTOR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Register index as taken from the word address bit of paddr.
  localparam logic REG_SIEVE_LIMIT = 1'b0;

  typedef struct packed {
    logic                start;
    logic [FACTOR_W-1:0] dividend;
    logic [FACTOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] quotient;
    logic [FACTOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/stdf_divider.sv -----
// ----------------------------------------------------------------------------
// Sieve factorizer divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_divider import stdf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 running;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FACTOR_W-1:0]  rem;
  logic [FACTOR_W-1:0]  quo;
  logic [FACTOR_W-1:0]  dsr;
  logic [FACTOR_W:0]    rem_sh;
  logic [FACTOR_W:0]    diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem, quo[FACTOR_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        dsr     <= req.divisor;
      end else if (running) begin
        rem <= ge ? diff[FACTOR_W-1:0] : rem_sh[FACTOR_W-1:0];
        quo <= {quo[FACTOR_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Divider done lasted more than one cycle.");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(req.start && running))
    else $error("Divider was started while a division was running.");
  a_start_runs: assert property (@(posedge clk) disable iff (rst) req.start |=> running)
    else $error("Divider did not begin after a start.");

endmodule

`default_nettype wire

// ----- rtl/stdf_sieve.sv -----
// ----------------------------------------------------------------------------
// Sieve factorizer prime map
// One-bit prime map in a memory, rebuilt by the Sieve of Eratosthenes.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_sieve import stdf_pkg::*; #(
  parameter  int SIEVE_SIZE = 65536,
  localparam int AW         = $clog2(SIEVE_SIZE)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rebuild,
  input  wire logic [LIMIT_W-1:0] limit,
  input  wire logic [AW-1:0]      walk_addr,
  output logic                    prime_bit,
  output logic                    ready,
  output logic [AW-1:0]           eff_limit
);

  localparam int LW = (AW > LIMIT_W) ? AW : LIMIT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] base;
  logic [AW:0]   sq;
  logic [AW:0]   mult;
  logic [AW:0]   mult_next;
  logic [LW-1:0] lim_ext;
  logic [LW-1:0] lim_max;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;
  logic [AW-1:0] ra;

  logic mem [SIEVE_SIZE];

  always_comb begin
    lim_ext   = LW'(limit);
    lim_max   = LW'(SIEVE_SIZE - 1);
    eff_limit = (lim_ext > lim_max) ? lim_max[AW-1:0] : lim_ext[AW-1:0];
    mult_next = mult + {1'b0, base};
    we        = (state == S_FILL) || (state == S_MARK);
    wa        = (state == S_FILL) ? fill_addr : mult[AW-1:0];
    wd        = (state == S_FILL) && (fill_addr >= AW'(2));
    ra        = (state == S_IDLE) ? walk_addr : base;
    ready     = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    prime_bit <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      state     <= S_FILL;
      fill_addr <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == eff_limit) begin
            base  <= AW'(2);
            sq    <= (AW + 1)'(4);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (sq > {1'b0, eff_limit}) ? S_IDLE : S_WAIT;
        end
        S_WAIT: begin
          if (prime_bit) begin
            mult  <= sq;
            state <= S_MARK;
          end else begin
            base  <= base + 1'b1;
            sq    <= sq + {base, 1'b1};
            state <= S_CHECK;
          end
        end
        S_MARK: begin
          if (mult_next > {1'b0, eff_limit}) begin
            base  <= base + 1'b1;
            sq    <= sq + {base, 1'b1};
            state <= S_CHECK;
          end else begin
            mult <= mult_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sieve_trial_division_factorizer_top.sv -----
// ----------------------------------------------------------------------------
// Sieve trial division factorizer
// Factors each number by trial division over a sieved prime map.
//
//   Channel   Signals                         Direction
//   command   start, busy, number             in, busy out
//   result    valid, factor, last             out, one cycle each
//   config    psel, penable, pwrite, paddr,   APB, register 0 = sieve_limit
//             pwdata, prdata, pready
//
// After reset or a write of sieve_limit, busy stays high while the map is rebuilt:
// the map is filled up to the clamped limit L, then each base up to sqrt(L) is checked
// and the multiples of each prime base are marked. A number is then tried against each
// prime candidate up to sqrt of the remaining value and the sieve limit, with one division
// per prime tried and per factor found, then finished; zero and one go straight to the last word.
// Reset is synchronous; the receiver cannot stall, results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module sieve_trial_division_factorizer_top import stdf_pkg::*; #(
  parameter int SIEVE_SIZE = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FACTOR_W-1:0] number,
  output logic                     valid,
  output logic [FACTOR_W-1:0]      factor,
  output logic                     last,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int AW = $clog2(SIEVE_SIZE);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CHECK = 3'd1;
  localparam logic [2:0] F_WAIT  = 3'd2;
  localparam logic [2:0] F_DIV   = 3'd3;
  localparam logic [2:0] F_FIN   = 3'd4;
  localparam logic [2:0] F_LAST  = 3'd5;

  logic [2:0]          fstate;
  logic [FACTOR_W-1:0] num;
  logic [AW:0]         p;
  logic [31:0]         psq;
  logic [FACTOR_W-1:0] pend;
  logic                pend_valid;
  logic [LIMIT_W-1:0]  sieve_limit;
  logic                cfg_wr;
  logic                sieve_ready;
  logic                prime_bit;
  logic [AW-1:0]       eff_limit;
  logic                accept;
  logic                div_hit;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIEVE_LIMIT);
  assign prdata = (paddr[2] == REG_SIEVE_LIMIT) ? PDATA_W'(sieve_limit) : '0;
  assign busy   = (fstate != F_IDLE) || !sieve_ready;
  assign accept = start && !busy;

  always_comb begin
    div_hit          = div_rsp.done && (div_rsp.remainder == '0);
    div_req.divisor  = FACTOR_W'(p);
    div_req.start    = ((fstate == F_WAIT) && prime_bit) || ((fstate == F_DIV) && div_hit);
    div_req.dividend = (fstate == F_DIV) ? div_rsp.quotient : num;
  end

  stdf_sieve #(
    .SIEVE_SIZE (SIEVE_SIZE)
  ) u_sieve (
    .clk       (clk),
    .rst       (rst),
    .rebuild   (cfg_wr),
    .limit     (sieve_limit),
    .walk_addr (p[AW-1:0]),
    .prime_bit (prime_bit),
    .ready     (sieve_ready),
    .eff_limit (eff_limit)
  );

  stdf_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate      <= F_IDLE;
      valid       <= 1'b0;
      pend_valid  <= 1'b0;
      sieve_limit <= LIMIT_RESET;
    end else begin
      valid <= 1'b0;
      if (cfg_wr) begin
        sieve_limit <= pwdata[LIMIT_W-1:0];
      end
      unique case (fstate)
        F_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            if (number < FACTOR_W'(2)) begin
              pend   <= '0;
              fstate <= F_LAST;
            end else begin
              num    <= number;
              p      <= (AW + 1)'(2);
              psq    <= 32'd4;
              fstate <= F_CHECK;
            end
          end
        end
        F_CHECK: begin
          if ((p > {1'b0, eff_limit}) || (psq > {1'b0, num})) begin
            fstate <= F_FIN;
          end else begin
            fstate <= F_WAIT;
          end
        end
        F_WAIT: begin
          if (prime_bit) begin
            fstate <= F_DIV;
          end else begin
            p      <= p + 1'b1;
            psq    <= psq + 32'({p, 1'b1});
            fstate <= F_CHECK;
          end
        end
        F_DIV: begin
          if (div_hit) begin
            num        <= div_rsp.quotient;
            pend       <= FACTOR_W'(p);
            pend_valid <= 1'b1;
            if (pend_valid) begin
              valid  <= 1'b1;
              factor <= pend;
              last   <= 1'b0;
            end
          end else if (div_rsp.done) begin
            p      <= p + 1'b1;
            psq    <= psq + 32'({p, 1'b1});
            fstate <= F_CHECK;
          end
        end
        F_FIN: begin
          if (num > FACTOR_W'(1)) begin
            pend <= num;
            if (pend_valid) begin
              valid  <= 1'b1;
              factor <= pend;
              last   <= 1'b0;
            end
          end
          fstate <= F_LAST;
        end
        F_LAST: begin
          valid  <= 1'b1;
          factor <= pend;
          last   <= 1'b1;
          fstate <= F_IDLE;
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("Block was not busy after taking a number.");
  a_last_alone: assert property (@(posedge clk) disable iff (rst) (valid && last) |=> !valid)
    else $error("A word followed the last word of a number.");
  a_word_in_work: assert property (@(posedge clk) disable iff (rst)
      valid |-> ((fstate != F_IDLE) || last))
    else $error("A non-final word appeared with the block idle.");

endmodule

`default_nettype wire
